/* sv/gceu_pkg.sv */
// Shared types, constants and codes of the graphics CPU execute unit.
package gceu_pkg;

   localparam int DATA_WORDS  = 4096;
   localparam int DOT_LENGTH  = 4;
   localparam int ADDR_W      = $clog2(DATA_WORDS);
   localparam int REG_COUNT   = 32;
   localparam int REG_W       = 5;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_IW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);
   localparam int CLEAR_LEN   = (DATA_WORDS > REG_COUNT) ? DATA_WORDS : REG_COUNT;
   localparam int CLEAR_W     = $clog2(CLEAR_LEN);
   localparam int DOT_W       = (DOT_LENGTH > 1) ? $clog2(DOT_LENGTH) : 1;
   localparam int RECIP_BITS  = 31;
   localparam int RECIP_CW    = $clog2(RECIP_BITS);
   localparam logic [REG_W-1:0] LINK_REG = 5'd31;

   typedef enum logic [4:0] {
      OP_LD   = 5'd0,  OP_ST   = 5'd1,  OP_LI   = 5'd2,  OP_ADD  = 5'd3,
      OP_SUB  = 5'd4,  OP_MUL  = 5'd5,  OP_MULF = 5'd6,  OP_RECP = 5'd7,
      OP_TST  = 5'd8,  OP_AND  = 5'd9,  OP_OR   = 5'd10, OP_XOR  = 5'd11,
      OP_NOT  = 5'd12, OP_LSL  = 5'd13, OP_LSR  = 5'd14, OP_ASR  = 5'd15,
      OP_LSLI = 5'd16, OP_LSRI = 5'd17, OP_ASRI = 5'd18, OP_JMP  = 5'd19,
      OP_CALL = 5'd20, OP_JEQ  = 5'd21, OP_JNE  = 5'd22, OP_JLT  = 5'd23,
      OP_JLE  = 5'd24, OP_JGT  = 5'd25, OP_JGE  = 5'd26, OP_DOT  = 5'd27,
      OP_CLIP = 5'd28
   } opcode_type;

   typedef enum logic [3:0] {
      CLS_ALU, CLS_LOAD, CLS_STORE, CLS_MUL, CLS_RECP,
      CLS_BRANCH, CLS_DOT, CLS_FLAGS, CLS_NOP
   } class_type;

   typedef enum logic [1:0] {
      FAULT_NONE = 2'd0,
      FAULT_ADDR = 2'd1,
      FAULT_DIV  = 2'd2
   } fault_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_REG, ST_EXEC, ST_LOAD, ST_MULR, ST_DIV, ST_RECPF,
      ST_DOTA, ST_DOTB, ST_DOTM, ST_DOTC, ST_WB
   } state_type;

   typedef struct packed {
      logic [4:0]        opcode;
      logic [4:0]        dest_reg;
      logic [4:0]        src_a_reg;
      logic [4:0]        src_b_reg;
      logic signed [15:0] immediate;
      logic [11:0]       return_address;
   } req_type;

   typedef struct packed {
      logic [31:0] written_value;
      logic        reg_written;
      logic        branch_taken;
      logic [11:0] branch_target;
      logic        flag_negative;
      logic        flag_zero;
      logic [1:0]  fault;
   } rsp_type;

   typedef struct packed {
      req_type   req;
      class_type cls;
   } item_type;

endpackage

/* sv/gceu_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module gceu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* sv/gceu_front.sv */
// Front part: accepts instructions, classifies them and queues them for the back part.
module gceu_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  gceu_pkg::req_type req_data,
   output logic              q_valid,
   output gceu_pkg::item_type q_item,
   input  logic              q_pop
);

   gceu_pkg::item_type                  entries_ff [gceu_pkg::QUEUE_DEPTH];
   logic [gceu_pkg::QUEUE_IW-1:0]       head_ff, head_in;
   logic [gceu_pkg::QUEUE_CW-1:0]       count_ff, count_in;
   logic [gceu_pkg::QUEUE_IW-1:0]       tail;
   logic                                accept;
   gceu_pkg::item_type                  item_new;

   function automatic gceu_pkg::class_type classify(input logic [4:0] op);
      gceu_pkg::class_type c;
      case (op)
         gceu_pkg::OP_LD:   c = gceu_pkg::CLS_LOAD;
         gceu_pkg::OP_ST:   c = gceu_pkg::CLS_STORE;
         gceu_pkg::OP_MUL, gceu_pkg::OP_MULF: c = gceu_pkg::CLS_MUL;
         gceu_pkg::OP_RECP: c = gceu_pkg::CLS_RECP;
         gceu_pkg::OP_TST, gceu_pkg::OP_CLIP: c = gceu_pkg::CLS_FLAGS;
         gceu_pkg::OP_JMP, gceu_pkg::OP_CALL, gceu_pkg::OP_JEQ, gceu_pkg::OP_JNE,
         gceu_pkg::OP_JLT, gceu_pkg::OP_JLE, gceu_pkg::OP_JGT, gceu_pkg::OP_JGE:
            c = gceu_pkg::CLS_BRANCH;
         gceu_pkg::OP_DOT:  c = gceu_pkg::CLS_DOT;
         gceu_pkg::OP_LI, gceu_pkg::OP_ADD, gceu_pkg::OP_SUB, gceu_pkg::OP_AND,
         gceu_pkg::OP_OR, gceu_pkg::OP_XOR, gceu_pkg::OP_NOT, gceu_pkg::OP_LSL,
         gceu_pkg::OP_LSR, gceu_pkg::OP_ASR, gceu_pkg::OP_LSLI, gceu_pkg::OP_LSRI,
         gceu_pkg::OP_ASRI: c = gceu_pkg::CLS_ALU;
         default:           c = gceu_pkg::CLS_NOP;
      endcase
      return c;
   endfunction

   assign full     = (count_ff == gceu_pkg::QUEUE_CW'(gceu_pkg::QUEUE_DEPTH));
   assign accept   = push && !full;
   assign q_valid  = (count_ff != '0);
   assign q_item   = entries_ff[head_ff];
   assign tail     = gceu_pkg::QUEUE_IW'(head_ff + count_ff);
   assign item_new = '{req: req_data, cls: classify(req_data.opcode)};

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (q_pop && q_valid) begin
         head_in = gceu_pkg::QUEUE_IW'(head_ff + 1'b1);
      end
      count_in = gceu_pkg::QUEUE_CW'(count_ff + accept - (q_pop && q_valid));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
      if (accept) begin
         entries_ff[tail] <= item_new;
      end
   end

endmodule

/* sv/gceu_back.sv */
// Back part: register file, data memory, flags and the execute sequencer.
module gceu_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  gceu_pkg::item_type  q_item,
   output logic                q_pop,
   output logic                empty,
   input  logic                pop,
   output gceu_pkg::rsp_type   rsp_data
);

   localparam int AW = gceu_pkg::ADDR_W;

   gceu_pkg::state_type state_ff, state_in;
   gceu_pkg::item_type  item_ff, item_in;
   gceu_pkg::rsp_type   res_ff, res_in, out_ff, out_in;
   logic                out_valid_ff, out_valid_in;
   logic [4:0]          widx_ff, widx_in;
   logic                setf_ff, setf_in;
   logic [31:0]         fsrc_ff, fsrc_in;
   logic                nf_ff, nf_in, zf_ff, zf_in;
   logic [gceu_pkg::CLEAR_W-1:0] clr_ff, clr_in;
   logic [63:0]         prod_ff, prod_in;
   logic [31:0]         rem_ff, rem_in, dmag_ff, dmag_in;
   logic [30:0]         quo_ff, quo_in;
   logic                neg_ff, neg_in;
   logic [gceu_pkg::RECIP_CW-1:0] dcnt_ff, dcnt_in;
   logic [AW-1:0]       dota_ff, dota_in, dotb_ff, dotb_in;
   logic [gceu_pkg::DOT_W-1:0] di_ff, di_in;
   logic [31:0]         dotx_ff, dotx_in, acc_ff, acc_in;

   logic [31:0] ra_data, rb_data, rd_data, mem_rdata;
   logic        rf_we, mem_we;
   logic [4:0]  rf_waddr;
   logic [31:0] rf_wdata, mem_wdata;
   logic [AW-1:0] mem_waddr, mem_raddr;

   logic [31:0] addr, val, q32, qs;
   logic        addr_ok, dot_ok;
   logic [32:0] t;
   logic        ge;
   logic signed [31:0] mx, my;
   logic signed [63:0] ps;
   logic signed [32:0] cx, cy;
   logic        nf_w, zf_w;
   logic [4:0]  sh;

   gceu_ram #(.WIDTH(32), .DEPTH(gceu_pkg::REG_COUNT)) u_rf_a (
      .clock(clock), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
      .raddr(item_ff.req.src_a_reg), .rdata(ra_data));
   gceu_ram #(.WIDTH(32), .DEPTH(gceu_pkg::REG_COUNT)) u_rf_b (
      .clock(clock), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
      .raddr(item_ff.req.src_b_reg), .rdata(rb_data));
   gceu_ram #(.WIDTH(32), .DEPTH(gceu_pkg::REG_COUNT)) u_rf_d (
      .clock(clock), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
      .raddr(item_ff.req.dest_reg), .rdata(rd_data));
   gceu_ram #(.WIDTH(32), .DEPTH(gceu_pkg::DATA_WORDS)) u_dmem (
      .clock(clock), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
      .raddr(mem_raddr), .rdata(mem_rdata));

   assign addr    = 32'({{16{item_ff.req.immediate[15]}}, item_ff.req.immediate}) + ra_data;
   assign addr_ok = addr < 32'(gceu_pkg::DATA_WORDS);
   assign dot_ok  = (({1'b0, ra_data} + 33'(gceu_pkg::DOT_LENGTH - 1))
                     < 33'(gceu_pkg::DATA_WORDS))
                 && (({1'b0, rb_data} + 33'(gceu_pkg::DOT_LENGTH - 1))
                     < 33'(gceu_pkg::DATA_WORDS));
   assign mx      = (state_ff == gceu_pkg::ST_DOTM) ? dotx_ff : ra_data;
   assign my      = (state_ff == gceu_pkg::ST_DOTM) ? mem_rdata : rb_data;
   assign ps      = mx * my;
   assign t       = {rem_ff, 1'b1};
   assign ge      = t >= {1'b0, dmag_ff};
   assign q32     = {1'b0, quo_ff};
   assign qs      = neg_ff ? (~q32 + 32'd1) : q32;
   assign cx      = 33'(signed'(rd_data));
   assign cy      = 33'(signed'(ra_data));
   assign nf_w    = setf_ff ? fsrc_ff[31] : nf_ff;
   assign zf_w    = setf_ff ? (fsrc_ff == 32'd0) : zf_ff;
   assign empty   = !out_valid_ff;
   assign rsp_data = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gceu_pkg::ST_CLEAR;
         out_valid_ff <= 1'b0;
         nf_ff        <= 1'b0;
         zf_ff        <= 1'b0;
         clr_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         nf_ff        <= nf_in;
         zf_ff        <= zf_in;
         clr_ff       <= clr_in;
      end
      item_ff <= item_in;
      res_ff  <= res_in;
      out_ff  <= out_in;
      widx_ff <= widx_in;
      setf_ff <= setf_in;
      fsrc_ff <= fsrc_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      dmag_ff <= dmag_in;
      quo_ff  <= quo_in;
      neg_ff  <= neg_in;
      dcnt_ff <= dcnt_in;
      dota_ff <= dota_in;
      dotb_ff <= dotb_in;
      di_ff   <= di_in;
      dotx_ff <= dotx_in;
      acc_ff  <= acc_in;
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !pop;
      widx_in      = widx_ff;
      setf_in      = setf_ff;
      fsrc_in      = fsrc_ff;
      nf_in        = nf_ff;
      zf_in        = zf_ff;
      clr_in       = clr_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      dmag_in      = dmag_ff;
      quo_in       = quo_ff;
      neg_in       = neg_ff;
      dcnt_in      = dcnt_ff;
      dota_in      = dota_ff;
      dotb_in      = dotb_ff;
      di_in        = di_ff;
      dotx_in      = dotx_ff;
      acc_in       = acc_ff;
      q_pop        = 1'b0;
      rf_we        = 1'b0;
      rf_waddr     = widx_ff;
      rf_wdata     = res_ff.written_value;
      mem_we       = 1'b0;
      mem_waddr    = addr[AW-1:0];
      mem_wdata    = rd_data;
      mem_raddr    = addr[AW-1:0];
      val          = 32'd0;
      sh           = 5'd0;
      case (state_ff)
         gceu_pkg::ST_CLEAR: begin
            mem_we    = ({1'b0, clr_ff} < (gceu_pkg::CLEAR_W + 1)'(gceu_pkg::DATA_WORDS));
            mem_waddr = clr_ff[AW-1:0];
            mem_wdata = 32'd0;
            rf_we     = ({1'b0, clr_ff} < (gceu_pkg::CLEAR_W + 1)'(gceu_pkg::REG_COUNT));
            rf_waddr  = clr_ff[4:0];
            rf_wdata  = 32'd0;
            clr_in    = gceu_pkg::CLEAR_W'(clr_ff + 1'b1);
            if (clr_ff == gceu_pkg::CLEAR_W'(gceu_pkg::CLEAR_LEN - 1)) begin
               state_in = gceu_pkg::ST_IDLE;
            end
         end
         gceu_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               item_in  = q_item;
               state_in = gceu_pkg::ST_REG;
            end
         end
         gceu_pkg::ST_REG: begin
            state_in = gceu_pkg::ST_EXEC;
         end
         gceu_pkg::ST_EXEC: begin
            res_in   = '0;
            widx_in  = item_ff.req.dest_reg;
            setf_in  = 1'b0;
            state_in = gceu_pkg::ST_WB;
            case (item_ff.cls)
               gceu_pkg::CLS_ALU: begin
                  sh = (item_ff.req.opcode >= gceu_pkg::OP_LSLI)
                     ? item_ff.req.immediate[4:0] : rb_data[4:0];
                  case (item_ff.req.opcode)
                     gceu_pkg::OP_LI:  val = addr;
                     gceu_pkg::OP_ADD: val = ra_data + rb_data;
                     gceu_pkg::OP_SUB: val = ra_data - rb_data;
                     gceu_pkg::OP_AND: val = ra_data & rb_data;
                     gceu_pkg::OP_OR:  val = ra_data | rb_data;
                     gceu_pkg::OP_XOR: val = ra_data ^ rb_data;
                     gceu_pkg::OP_NOT: val = ~ra_data;
                     gceu_pkg::OP_LSL, gceu_pkg::OP_LSLI: val = ra_data << sh;
                     gceu_pkg::OP_LSR, gceu_pkg::OP_LSRI: val = ra_data >> sh;
                     default: val = $unsigned($signed(ra_data) >>> sh);
                  endcase
                  res_in.written_value = val;
                  res_in.reg_written   = 1'b1;
                  setf_in = 1'b1;
                  fsrc_in = val;
               end
               gceu_pkg::CLS_LOAD: begin
                  if (addr_ok) begin
                     state_in = gceu_pkg::ST_LOAD;
                  end else begin
                     res_in.fault = gceu_pkg::FAULT_ADDR;
                  end
               end
               gceu_pkg::CLS_STORE: begin
                  if (addr_ok) begin
                     mem_we = 1'b1;
                     res_in.written_value = rd_data;
                     setf_in = 1'b1;
                     fsrc_in = rd_data;
                  end else begin
                     res_in.fault = gceu_pkg::FAULT_ADDR;
                  end
               end
               gceu_pkg::CLS_MUL: begin
                  prod_in  = ps;
                  state_in = gceu_pkg::ST_MULR;
               end
               gceu_pkg::CLS_RECP: begin
                  if (ra_data == 32'd0) begin
                     res_in.fault = gceu_pkg::FAULT_DIV;
                     setf_in = 1'b1;
                     fsrc_in = rd_data;
                  end else begin
                     neg_in   = ra_data[31];
                     dmag_in  = ra_data[31] ? (~ra_data + 32'd1) : ra_data;
                     rem_in   = 32'd0;
                     quo_in   = '0;
                     dcnt_in  = '0;
                     state_in = gceu_pkg::ST_DIV;
                  end
               end
               gceu_pkg::CLS_BRANCH: begin
                  if (addr_ok) begin
                     res_in.branch_target = addr[11:0];
                     case (item_ff.req.opcode)
                        gceu_pkg::OP_JMP: res_in.branch_taken = 1'b1;
                        gceu_pkg::OP_CALL: begin
                           res_in.branch_taken  = 1'b1;
                           res_in.reg_written   = 1'b1;
                           res_in.written_value = 32'(item_ff.req.return_address);
                           widx_in = gceu_pkg::LINK_REG;
                        end
                        gceu_pkg::OP_JEQ: res_in.branch_taken = zf_ff;
                        gceu_pkg::OP_JNE: res_in.branch_taken = !zf_ff;
                        gceu_pkg::OP_JLT: res_in.branch_taken = nf_ff;
                        gceu_pkg::OP_JLE: res_in.branch_taken = nf_ff || zf_ff;
                        gceu_pkg::OP_JGT: res_in.branch_taken = !(nf_ff || zf_ff);
                        default:          res_in.branch_taken = !nf_ff;
                     endcase
                  end else begin
                     res_in.fault = gceu_pkg::FAULT_ADDR;
                  end
               end
               gceu_pkg::CLS_DOT: begin
                  if (dot_ok) begin
                     dota_in  = ra_data[AW-1:0];
                     dotb_in  = rb_data[AW-1:0];
                     di_in    = '0;
                     acc_in   = 32'd0;
                     state_in = gceu_pkg::ST_DOTA;
                  end else begin
                     res_in.fault = gceu_pkg::FAULT_ADDR;
                  end
               end
               gceu_pkg::CLS_FLAGS: begin
                  if (item_ff.req.opcode == gceu_pkg::OP_TST) begin
                     setf_in = 1'b1;
                     fsrc_in = rd_data;
                  end else begin
                     zf_in = cx > cy;
                     nf_in = cx < -cy;
                  end
               end
               default: begin
               end
            endcase
         end
         gceu_pkg::ST_LOAD: begin
            res_in.written_value = mem_rdata;
            res_in.reg_written   = 1'b1;
            setf_in  = 1'b1;
            fsrc_in  = mem_rdata;
            state_in = gceu_pkg::ST_WB;
         end
         gceu_pkg::ST_MULR: begin
            val = (item_ff.req.opcode == gceu_pkg::OP_MUL) ? prod_ff[31:0] : prod_ff[47:16];
            res_in.written_value = val;
            res_in.reg_written   = 1'b1;
            setf_in  = 1'b1;
            fsrc_in  = val;
            state_in = gceu_pkg::ST_WB;
         end
         gceu_pkg::ST_DIV: begin
            rem_in  = ge ? 32'(t - {1'b0, dmag_ff}) : t[31:0];
            quo_in  = {quo_ff[29:0], ge};
            dcnt_in = gceu_pkg::RECIP_CW'(dcnt_ff + 1'b1);
            if (dcnt_ff == gceu_pkg::RECIP_CW'(gceu_pkg::RECIP_BITS - 1)) begin
               state_in = gceu_pkg::ST_RECPF;
            end
         end
         gceu_pkg::ST_RECPF: begin
            val = (qs + 32'd1) << 1;
            res_in.written_value = val;
            res_in.reg_written   = 1'b1;
            setf_in  = 1'b1;
            fsrc_in  = val;
            state_in = gceu_pkg::ST_WB;
         end
         gceu_pkg::ST_DOTA: begin
            mem_raddr = AW'(dota_ff + di_ff);
            state_in  = gceu_pkg::ST_DOTB;
         end
         gceu_pkg::ST_DOTB: begin
            mem_raddr = AW'(dotb_ff + di_ff);
            dotx_in   = mem_rdata;
            state_in  = gceu_pkg::ST_DOTM;
         end
         gceu_pkg::ST_DOTM: begin
            prod_in  = ps;
            state_in = gceu_pkg::ST_DOTC;
         end
         gceu_pkg::ST_DOTC: begin
            acc_in = acc_ff + prod_ff[47:16];
            di_in  = gceu_pkg::DOT_W'(di_ff + 1'b1);
            if (di_ff == gceu_pkg::DOT_W'(gceu_pkg::DOT_LENGTH - 1)) begin
               res_in.written_value = acc_ff + prod_ff[47:16];
               res_in.reg_written   = 1'b1;
               setf_in  = 1'b1;
               fsrc_in  = acc_ff + prod_ff[47:16];
               state_in = gceu_pkg::ST_WB;
            end else begin
               state_in = gceu_pkg::ST_DOTA;
            end
         end
         gceu_pkg::ST_WB: begin
            if (!out_valid_ff) begin
               rf_we        = res_ff.reg_written;
               nf_in        = nf_w;
               zf_in        = zf_w;
               out_in       = res_ff;
               out_in.flag_negative = nf_w;
               out_in.flag_zero     = zf_w;
               out_valid_in = 1'b1;
               state_in     = gceu_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gceu_pkg::ST_IDLE;
         end
      endcase
   end

`ifndef SYNTH
   a_no_pop_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gceu_pkg::ST_CLEAR) |-> !q_pop)
      else $error("item taken during clearing pass");
   a_fault_no_effect: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gceu_pkg::ST_WB && res_ff.fault != gceu_pkg::FAULT_NONE)
      |-> (!res_ff.reg_written && !res_ff.branch_taken))
      else $error("faulting item writes or branches");
   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gceu_pkg::ST_DIV)
      |=> (state_ff == gceu_pkg::ST_DIV || state_ff == gceu_pkg::ST_RECPF))
      else $error("divider left early");
   a_wb_holds_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gceu_pkg::ST_WB && out_valid_ff && !pop) |=> (state_ff == gceu_pkg::ST_WB))
      else $error("result overwritten");
`endif

endmodule

/* sv/graphics_cpu_execute_unit.sv */
// Top level of the graphics CPU execute unit: front queue and execute back part.
// The back sequencer handles one item at a time and holds in writeback while a result
// waits. Each item is read from the register file, executed, passed through extra
// states for load, mul, reciprocal and dot items, and written back. After reset a
// clearing pass zeroes memory and registers; up to two items queue meanwhile, then
// full holds high.
module graphics_cpu_execute_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  gceu_pkg::req_type req_data,
   output logic              empty,
   input  logic              pop,
   output gceu_pkg::rsp_type rsp_data
);

   logic               q_valid;
   logic               q_pop;
   gceu_pkg::item_type q_item;

   gceu_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_data(req_data),
      .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop));

   gceu_back u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
      .empty(empty), .pop(pop), .rsp_data(rsp_data));

endmodule

/* sim/graphics_cpu_execute_unit_checker.sv */
// Checker for the graphics CPU execute unit: predicts each result and compares it.
`timescale 1ns / 100ps
module graphics_cpu_execute_unit_checker
   import gceu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  logic    full,
   input  req_type req_data,
   input  logic    empty,
   input  logic    pop,
   input  rsp_type rsp_data,
   output int      failures,
   output int      pending
);

   logic [31:0] regs [REG_COUNT];
   logic [31:0] mem [DATA_WORDS];
   logic        neg_flag;
   logic        zero_flag;
   rsp_type     expected_q [$];

   function automatic logic addr_valid(logic [31:0] a);
      return a < DATA_WORDS;
   endfunction

   function automatic logic [31:0] fixed_mul(logic [31:0] a, logic [31:0] b);
      longint p;
      p = longint'($signed(a)) * longint'($signed(b));
      return 32'(p >>> 16);
   endfunction

   task automatic set_nz(logic [31:0] v);
      neg_flag  = v[31];
      zero_flag = (v == 0);
   endtask

   task automatic execute(input req_type r, output rsp_type o);
      logic [31:0] a, b, imm, addr, val;
      logic        res;
      longint      q, x, y;
      a    = regs[r.src_a_reg];
      b    = regs[r.src_b_reg];
      imm  = 32'(r.immediate);
      addr = imm + a;
      val  = 0;
      res  = 0;
      o    = '0;
      case (opcode_type'(r.opcode))
         OP_LD: begin
            if (!addr_valid(addr)) o.fault = FAULT_ADDR;
            else begin val = mem[addr[ADDR_W-1:0]]; res = 1; end
         end
         OP_ST: begin
            if (!addr_valid(addr)) o.fault = FAULT_ADDR;
            else begin
               o.written_value = regs[r.dest_reg];
               mem[addr[ADDR_W-1:0]] = regs[r.dest_reg];
               set_nz(regs[r.dest_reg]);
            end
         end
         OP_LI:   begin val = addr; res = 1; end
         OP_ADD:  begin val = a + b; res = 1; end
         OP_SUB:  begin val = a - b; res = 1; end
         OP_MUL:  begin val = a * b; res = 1; end
         OP_MULF: begin val = fixed_mul(a, b); res = 1; end
         OP_RECP: begin
            if (a == 0) begin
               o.fault = FAULT_DIV;
               set_nz(regs[r.dest_reg]);
            end else begin
               q   = 64'sh7fffffff / longint'($signed(a));
               val = 32'(q + 1) << 1;
               res = 1;
            end
         end
         OP_TST:  set_nz(regs[r.dest_reg]);
         OP_AND:  begin val = a & b; res = 1; end
         OP_OR:   begin val = a | b; res = 1; end
         OP_XOR:  begin val = a ^ b; res = 1; end
         OP_NOT:  begin val = ~a; res = 1; end
         OP_LSL:  begin val = a << b[4:0]; res = 1; end
         OP_LSR:  begin val = a >> b[4:0]; res = 1; end
         OP_ASR:  begin val = $signed(a) >>> b[4:0]; res = 1; end
         OP_LSLI: begin val = a << imm[4:0]; res = 1; end
         OP_LSRI: begin val = a >> imm[4:0]; res = 1; end
         OP_ASRI: begin val = $signed(a) >>> imm[4:0]; res = 1; end
         OP_JMP, OP_CALL, OP_JEQ, OP_JNE, OP_JLT, OP_JLE, OP_JGT, OP_JGE: begin
            if (!addr_valid(addr)) o.fault = FAULT_ADDR;
            else begin
               o.branch_target = addr[11:0];
               case (opcode_type'(r.opcode))
                  OP_JMP:  o.branch_taken = 1;
                  OP_CALL: begin
                     o.branch_taken     = 1;
                     regs[LINK_REG]     = 32'(r.return_address);
                     o.written_value    = 32'(r.return_address);
                     o.reg_written      = 1;
                  end
                  OP_JEQ:  o.branch_taken = zero_flag;
                  OP_JNE:  o.branch_taken = !zero_flag;
                  OP_JLT:  o.branch_taken = neg_flag;
                  OP_JLE:  o.branch_taken = neg_flag | zero_flag;
                  OP_JGT:  o.branch_taken = !(neg_flag | zero_flag);
                  default: o.branch_taken = !neg_flag;
               endcase
            end
         end
         OP_DOT: begin
            if (longint'(a) + DOT_LENGTH - 1 >= DATA_WORDS ||
                longint'(b) + DOT_LENGTH - 1 >= DATA_WORDS) o.fault = FAULT_ADDR;
            else begin
               for (int i = 0; i < DOT_LENGTH; i++)
                  val += fixed_mul(mem[a + i], mem[b + i]);
               res = 1;
            end
         end
         OP_CLIP: begin
            x = longint'($signed(regs[r.dest_reg]));
            y = longint'($signed(a));
            zero_flag = (x > y);
            neg_flag  = (x < -y);
         end
         default: ;
      endcase
      if (res) begin
         regs[r.dest_reg] = val;
         set_nz(val);
         o.written_value = val;
         o.reg_written   = 1;
      end
      o.flag_negative = neg_flag;
      o.flag_zero     = zero_flag;
   endtask

   task automatic report(string field, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
      failures++;
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         foreach (regs[i]) regs[i] = 0;
         foreach (mem[i]) mem[i] = 0;
         neg_flag  = 0;
         zero_flag = 0;
         expected_q.delete();
         failures  = 0;
      end else begin
         if (pop && !empty) begin
            if (expected_q.size() == 0) begin
               report("unexpected item", 32'd1, 32'd0);
            end else begin
               e = expected_q.pop_front();
               if (rsp_data.written_value != e.written_value)
                  report("written_value", rsp_data.written_value, e.written_value);
               if (rsp_data.reg_written != e.reg_written)
                  report("reg_written", rsp_data.reg_written, e.reg_written);
               if (rsp_data.branch_taken != e.branch_taken)
                  report("branch_taken", rsp_data.branch_taken, e.branch_taken);
               if (rsp_data.branch_target != e.branch_target)
                  report("branch_target", rsp_data.branch_target, e.branch_target);
               if (rsp_data.flag_negative != e.flag_negative)
                  report("flag_negative", rsp_data.flag_negative, e.flag_negative);
               if (rsp_data.flag_zero != e.flag_zero)
                  report("flag_zero", rsp_data.flag_zero, e.flag_zero);
               if (rsp_data.fault != e.fault)
                  report("fault", rsp_data.fault, e.fault);
            end
         end
         if (push && !full) begin
            execute(req_data, e);
            expected_q.push_back(e);
         end
      end
      pending <= expected_q.size();
   end

endmodule

/* sim/graphics_cpu_execute_unit_test.sv */
// Testbench top for the graphics CPU execute unit: stimulus, idling and verdict.
`timescale 1ns / 100ps
module graphics_cpu_execute_unit_test;
   import gceu_pkg::*;

   logic    clock;
   logic    reset;
   logic    push;
   logic    full;
   req_type req_data;
   logic    empty;
   logic    pop;
   rsp_type rsp_data;
   int      failures;
   int      pending;
   int      send_idle;
   int      recv_idle;
   int      cycles = 0;

   graphics_cpu_execute_unit dut (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data)
   );

   graphics_cpu_execute_unit_checker checker_inst (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data),
      .failures(failures), .pending(pending)
   );

   initial clock = 0;
   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   always @(posedge clock) begin
      if (reset) pop <= 0;
      else pop <= ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 600000) begin
         $display("FAIL graphics_cpu_execute_unit");
         $finish;
      end
   end

   function automatic req_type make(opcode_type op, int rd, int ra, int rb,
                                    int imm, int ret = 0);
      req_type r;
      r.opcode         = op;
      r.dest_reg       = rd[4:0];
      r.src_a_reg      = ra[4:0];
      r.src_b_reg      = rb[4:0];
      r.immediate      = imm[15:0];
      r.return_address = ret[11:0];
      return r;
   endfunction

   task automatic send(req_type r);
      while ($urandom_range(99) < send_idle) begin
         push <= 0;
         @(posedge clock);
      end
      push     <= 1;
      req_data <= r;
      @(negedge clock);
      while (full) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic load_bases();
      send(make(OP_XOR, 28, 28, 28, 0));
      send(make(OP_LI, 28, 28, 0, $urandom_range(64)));
      send(make(OP_XOR, 29, 29, 29, 0));
      send(make(OP_LI, 29, 29, 0, 3990 + $urandom_range(20)));
      send(make(OP_XOR, 30, 30, 30, 0));
      send(make(OP_LI, 30, 30, 0, $urandom_range(100, 3000)));
   endtask

   function automatic req_type random_item();
      req_type    r;
      opcode_type op;
      r = ($bits(req_type))'({$urandom, $urandom});
      r.opcode = 5'($urandom_range(28));
      if ($urandom_range(99) < 6) return r;
      op = opcode_type'(r.opcode);
      if (!(op inside {OP_ST, OP_TST, OP_CLIP})) r.dest_reg = 5'($urandom_range(27));
      case (op)
         OP_LD, OP_ST, OP_JMP, OP_CALL, OP_JEQ, OP_JNE, OP_JLT, OP_JLE, OP_JGT,
         OP_JGE: begin
            r.src_a_reg = 5'($urandom_range(28, 29));
            r.immediate = 16'(($urandom_range(9) == 0) ? -$urandom_range(1, 40)
                                                       : $urandom_range(110));
         end
         OP_DOT: begin
            r.src_a_reg = 5'($urandom_range(28, 30));
            r.src_b_reg = 5'($urandom_range(28, 30));
         end
         default: ;
      endcase
      return r;
   endfunction

   initial begin
      req_type directed [$];
      reset     = 1;
      push      = 0;
      req_data  = '0;
      send_idle = 11;
      recv_idle = 83;
      directed = '{
         make(OP_LI, 1, 0, 0, 32767), make(OP_LI, 2, 0, 0, -32768),
         make(OP_ADD, 3, 1, 2, 0), make(OP_SUB, 3, 2, 1, 0),
         make(OP_MUL, 4, 2, 2, 0), make(OP_MULF, 5, 2, 1, 0),
         make(OP_RECP, 6, 1, 0, 0), make(OP_RECP, 7, 0, 0, 0),
         make(OP_RECP, 8, 2, 0, 0), make(OP_TST, 2, 0, 0, 0),
         make(OP_AND, 9, 1, 2, 0), make(OP_OR, 9, 1, 2, 0),
         make(OP_XOR, 9, 1, 2, 0), make(OP_NOT, 9, 0, 0, 0),
         make(OP_LSL, 10, 1, 9, 0), make(OP_LSR, 10, 9, 9, 0),
         make(OP_ASR, 10, 2, 9, 0), make(OP_LSLI, 11, 1, 0, 33),
         make(OP_LSRI, 11, 9, 0, 31), make(OP_ASRI, 11, 2, 0, -1),
         make(OP_ST, 2, 0, 0, 4095), make(OP_ST, 1, 0, 0, 4096),
         make(OP_LD, 12, 0, 0, 4095), make(OP_LD, 12, 0, 0, -1),
         make(OP_JMP, 0, 0, 0, 4095), make(OP_CALL, 0, 0, 0, 5, 4095),
         make(OP_JEQ, 0, 0, 0, 7), make(OP_JNE, 0, 0, 0, 4096),
         make(OP_JLT, 0, 0, 0, 1), make(OP_JLE, 0, 0, 0, 2),
         make(OP_JGT, 0, 0, 0, 3), make(OP_JGE, 0, 0, 0, 4),
         make(OP_ST, 1, 0, 0, 0), make(OP_ST, 2, 0, 0, 3),
         make(OP_DOT, 13, 0, 0, 0), make(OP_DOT, 13, 0, 9, 0),
         make(OP_CLIP, 2, 1, 0, 0), make(OP_CLIP, 1, 2, 0, 0)
      };
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (directed[i]) send(directed[i]);
      for (int phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 11 : (phase == 1) ? 83 : 0;
         recv_idle = (phase == 0) ? 83 : (phase == 1) ? 11 : 0;
         load_bases();
         repeat (140) send(random_item());
      end
      push <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (failures == 0)
         $display("PASS graphics_cpu_execute_unit");
      else
         $display("FAIL graphics_cpu_execute_unit");
      $finish;
   end

endmodule
